>>> rtl/core/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV converter.
`timescale 1ns / 1ps
package rgbhsv_pkg;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_t;

  // Classified pixel passed from the front end to the divider back end.
  typedef struct packed {
    sector_t    sector;
    logic       neg;
    logic [7:0] diff;
    logic [7:0] delta;
    logic [7:0] maxv;
    logic [8:0] light;
  } class_t;

  localparam int HUE_W   = 15;
  localparam int SAT_W   = 16;

endpackage

>>> rtl/core/rgbhsv_front.sv
// Front end: accept pixels and sort them into sector, delta, max and min.
`timescale 1ns / 1ps
module rgbhsv_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             red,
  input  logic [7:0]             green,
  input  logic [7:0]             blue,
  output logic                   q_valid,
  input  logic                   q_ready,
  output rgbhsv_pkg::class_t     q_data
);
  import rgbhsv_pkg::*;

  logic [7:0] mx;
  logic [7:0] mn;
  class_t     cls;

  always_comb begin
    mx = (red >= green) ? red : green;
    if (blue > mx) mx = blue;
    mn = (red <= green) ? red : green;
    if (blue < mn) mn = blue;
    cls.maxv  = mx;
    cls.delta = mx - mn;
    cls.light = {1'b0, mx} + {1'b0, mn};
    if (mx == red) begin
      cls.sector = SECT_RED;
      cls.neg    = green < blue;
      cls.diff   = cls.neg ? blue - green : green - blue;
    end else if (mx == green) begin
      cls.sector = SECT_GREEN;
      cls.neg    = blue < red;
      cls.diff   = cls.neg ? red - blue : blue - red;
    end else begin
      cls.sector = SECT_BLUE;
      cls.neg    = red < green;
      cls.diff   = cls.neg ? green - red : red - green;
    end
  end

  // Two-entry skid queue toward the back end.
  logic [1:0] count;
  class_t     slot0, slot1;
  logic       push, pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_data   = slot0;
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= (count == 2'd2) ? slot1 : cls;
      if (count == 2'd2 && push) slot1 <= cls;
    end else if (push) begin
      if (count == 2'd0) slot0 <= cls;
      else slot1 <= cls;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push || pop) else $error("queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("bad count");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_ready |=> q_valid) else $error("queue lost entry");

endmodule

>>> rtl/core/rgbhsv_back.sv
// Back end: pipelined restoring dividers for hue and saturation.
`timescale 1ns / 1ps
module rgbhsv_back #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  rgbhsv_pkg::class_t     q_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [rgbhsv_pkg::HUE_W-1:0] hue_angle,
  output logic [rgbhsv_pkg::SAT_W-1:0] saturation,
  output logic [7:0]             value_level,
  output logic [8:0]             lightness_doubled
);
  import rgbhsv_pkg::*;

  // hue numerator 2*60*2^F*base + delta, base < 6*256
  localparam int HN_W  = 11 + 7 + HUE_FRAC_BITS + 1;
  localparam int SN_W  = 8 + SAT_FRAC_BITS;
  localparam int NW    = (HN_W > SN_W) ? HN_W : SN_W;
  localparam int STG   = NW;
  localparam int REM_W = 10;
  localparam logic [HN_W-1:0] FULL = HN_W'(360) << HUE_FRAC_BITS;
  localparam logic [SN_W-1:0] SCAP = (SAT_FRAC_BITS >= 16) ? SN_W'(16'hFFFF)
                                   : ((SN_W'(1) << SAT_FRAC_BITS) - SN_W'(1));

  typedef struct packed {
    logic [NW-1:0]    hq;
    logic [REM_W-1:0] hr;
    logic [NW-1:0]    sq;
    logic [REM_W-1:0] sr;
    logic [9:0]       hd;
    logic [7:0]       sd;
    logic             gray;
    logic [7:0]       maxv;
    logic [8:0]       light;
  } work_t;

  work_t       st  [STG+1];
  logic        vld [STG+1];
  logic        adv;
  logic [10:0] base;
  logic [HN_W-1:0] hnum;

  assign adv     = !out_valid || out_ready;
  assign q_ready = adv;

  always_comb begin
    unique case (q_data.sector)
      SECT_RED:   base = q_data.neg ? 11'(6 * q_data.delta) - 11'(q_data.diff)
                                    : 11'(q_data.diff);
      SECT_GREEN: base = q_data.neg ? 11'(2 * q_data.delta) - 11'(q_data.diff)
                                    : 11'(2 * q_data.delta) + 11'(q_data.diff);
      SECT_BLUE:  base = q_data.neg ? 11'(4 * q_data.delta) - 11'(q_data.diff)
                                    : 11'(4 * q_data.delta) + 11'(q_data.diff);
      default:    base = '0;
    endcase
    hnum = (HN_W'(base) * HN_W'(120) << HUE_FRAC_BITS) + HN_W'(q_data.delta);
  end

  always_comb begin
    st[0].hq    = NW'(hnum);
    st[0].hr    = '0;
    st[0].sq    = NW'({q_data.delta, {SAT_FRAC_BITS{1'b0}}});
    st[0].sr    = '0;
    st[0].hd    = {1'b0, q_data.delta, 1'b0};
    st[0].sd    = q_data.maxv;
    st[0].gray  = (q_data.delta == 8'd0);
    st[0].maxv  = q_data.maxv;
    st[0].light = q_data.light;
    vld[0]      = q_valid;
  end

  // One quotient bit per stage for each divider; the whole pipe moves together.
  for (genvar i = 0; i < STG; i++) begin : g_div
    work_t      nx;
    logic [REM_W:0] ht, s_t;
    always_comb begin
      nx  = st[i];
      ht  = {st[i].hr, st[i].hq[NW-1]};
      s_t = {st[i].sr, st[i].sq[NW-1]};
      nx.hq = {st[i].hq[NW-2:0], 1'b0};
      nx.sq = {st[i].sq[NW-2:0], 1'b0};
      if (ht >= {1'b0, st[i].hd}) begin
        nx.hr = REM_W'(ht - {1'b0, st[i].hd});
        nx.hq[0] = 1'b1;
      end else begin
        nx.hr = REM_W'(ht);
      end
      if (s_t >= (REM_W+1)'(st[i].sd)) begin
        nx.sr = REM_W'(s_t - (REM_W+1)'(st[i].sd));
        nx.sq[0] = 1'b1;
      end else begin
        nx.sr = REM_W'(s_t);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else if (adv) vld[i+1] <= vld[i];
    end
    always_ff @(posedge clk) begin
      if (adv) st[i+1] <= nx;
    end
  end

  logic [HN_W-1:0] hq;
  logic [SN_W-1:0] sq;
  assign hq        = HN_W'(st[STG].hq);
  assign sq        = SN_W'(st[STG].sq);
  assign out_valid = vld[STG];

  always_comb begin
    if (st[STG].gray) begin
      hue_angle  = '0;
      saturation = '0;
    end else begin
      hue_angle  = HUE_W'((hq >= FULL) ? hq - FULL : hq);
      saturation = SAT_W'((sq > SCAP) ? SCAP : sq);
    end
    value_level       = st[STG].maxv;
    lightness_doubled = st[STG].light;
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hue_angle))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> q_ready) else $error("back end stalled while empty");
  a_light: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lightness_doubled >= {1'b0, value_level})
    else $error("lightness below max");

endmodule

>>> rtl/core/rgb_to_hsv_convert.sv
// Top level of the RGB to HSV/HSL pixel converter.
`timescale 1ns / 1ps
// Converts one 8-bit RGB pixel per clock, unless stalled, into hue
// (1/2^HUE_FRAC_BITS degree, rounded to nearest), saturation (delta/max,
// Q0.SAT_FRAC_BITS, capped at 2^SAT_FRAC_BITS-1 or 65535, whichever is
// smaller), value (max channel) and doubled lightness (max plus min). Gray
// pixels give hue 0; black gives saturation 0. Throughput is one pixel per
// clock while the output is not stalled. A result passes through the
// front-end queue and then the divider stages, one stage per quotient bit.
// The stage count is the wider of the hue numerator (HUE_FRAC_BITS+19
// bits, 25 at the default sizes) and the saturation dividend
// (8+SAT_FRAC_BITS bits, 24 at the default sizes). A two-entry queue parts
// the classifier from the divider pipe so either side may stall.
module rgb_to_hsv_convert #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  // hue_angle[14:0], saturation[30:15], value_level[38:31],
  // lightness_doubled[47:39]
  output logic [47:0] m_tdata
);
  import rgbhsv_pkg::*;

  logic   q_valid, q_ready;
  class_t q_data;
  logic [HUE_W-1:0] hue_angle;
  logic [SAT_W-1:0] saturation;
  logic [7:0] value_level;
  logic [8:0] lightness_doubled;

  // Classify: sector, delta, max, min.
  rgbhsv_front u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .red(s_tdata[7:0]), .green(s_tdata[15:8]), .blue(s_tdata[23:16]),
    .q_valid, .q_ready, .q_data
  );

  // Divide: hue and saturation quotients.
  rgbhsv_back #(.HUE_FRAC_BITS(HUE_FRAC_BITS), .SAT_FRAC_BITS(SAT_FRAC_BITS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data,
    .out_valid(m_tvalid), .out_ready(m_tready),
    .hue_angle, .saturation, .value_level, .lightness_doubled
  );

  assign m_tdata = {lightness_doubled, value_level, saturation, hue_angle};

endmodule
